// ----- rtl/msrp_pkg.sv -----
// Shared constants, types and widths for the motor speed ramp with PWM output.
`default_nettype none

package msrp_pkg;

    // Full-scale speed in per-mille and the hardware PWM duty scale
    localparam int FULL_SCALE    = 1000;
    localparam int HW_DUTY_SCALE = 1000000;

    localparam int SPEED_W = 11;
    localparam int REQ_W   = 16;
    localparam int MAG_W   = 10;
    localparam int STEP_W  = 7;
    localparam int DUTY_W  = 20;
    localparam int PROD_W  = MAG_W + DUTY_W;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_SENSE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_LINE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HW_PWM      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SOFT_RANGE  = 3'd4;

    localparam logic [STEP_W-1:0] RAMP_STEP_RESET  = 7'd10;
    localparam logic [DUTY_W-1:0] SOFT_RANGE_RESET = 20'd255;

    // Divide by FULL_SCALE as a multiply by a rounded-up reciprocal
    localparam int DIV_SHIFT  = 40;
    localparam int DIV_MULT_W = 31;
    localparam logic [63:0] DIV_MULT_FULL =
        ((64'd1 << DIV_SHIFT) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE);
    localparam logic [DIV_MULT_W-1:0] DIV_MULT = DIV_MULT_FULL[DIV_MULT_W-1:0];

    // Word held between the ramp stage and the duty stage
    typedef struct packed {
        logic                      written;
        logic                      direction;
        logic                      enable;
        logic signed [SPEED_W-1:0] current;
        logic                      fault;
        logic [PROD_W-1:0]         prod;
    } t_s1;

endpackage

`default_nettype wire

// ----- rtl/msrp_duty_div.sv -----
// Duty count from magnitude-times-scale product, divided by full scale.
`default_nettype none

module msrp_duty_div
    import msrp_pkg::*;
(
    input  wire logic [PROD_W-1:0] i_prod,
    output logic      [DUTY_W-1:0] o_duty
);

    logic [PROD_W+DIV_MULT_W-1:0] full;

    // Reciprocal error stays below one quotient step over the whole product range
    assign full   = (PROD_W+DIV_MULT_W)'(i_prod) * (PROD_W+DIV_MULT_W)'(DIV_MULT);
    assign o_duty = full[DIV_SHIFT +: DUTY_W];

endmodule

`default_nettype wire

// ----- rtl/motor_speed_ramp_pwm_top.sv -----
// Motor speed ramp with PWM direction and duty output, top level.
//
// Input channel (i_valid / o_stall) takes one word per cycle while o_stall
// is low: a move word (i_cmd = 1) clamps i_speed_request to +-1000 per
// mille and sets the target; a tick word (i_cmd = 0) checks the fault pin
// when sensing is on, else, off target, ramps the current speed one step
// toward the target and writes the old speed out as direction and duty.
// Every word gives exactly one result word on the output (o_valid / i_stall).
// The ramp stage updates speed state and forms the magnitude times
// duty-scale product; the duty stage divides it by full scale with a
// reciprocal multiply into the output register.
// Throughput is one word per cycle; the two-stage pipeline keeps it while
// the receiver takes a result each cycle. When the receiver stalls, the
// result holds, the middle stage fills, then o_stall rises.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect on the
// next word; the user makes them while the block is idle; not enforced.
// Reset clears speed, target, enable, held direction and duty, empties the
// pipeline and loads register defaults: ramp step 10, software range 255.
`default_nettype none

module motor_speed_ramp_pwm_top
    import msrp_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,

    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [DUTY_W-1:0]         i_cfg_data,

    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic                      i_cmd,
    input  wire logic signed [REQ_W-1:0]   i_speed_request,
    input  wire logic                      i_fault_pin_level,

    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic                           o_pwm_written,
    output logic                           o_direction,
    output logic [DUTY_W-1:0]              o_duty,
    output logic                           o_enable_out,
    output logic signed [SPEED_W-1:0]      o_current_speed,
    output logic                           o_fault_stop
);

    localparam logic signed [REQ_W-1:0] REQ_MAX = REQ_W'(FULL_SCALE);
    localparam logic signed [REQ_W-1:0] REQ_MIN = -REQ_MAX;
    localparam logic signed [SPEED_W-1:0] SPEED_MAX = SPEED_W'(FULL_SCALE);
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = -SPEED_MAX;

    // Configuration
    logic [STEP_W-1:0] r_ramp_step;
    logic              r_fault_sense;
    logic              r_enable_line;
    logic              r_hw_pwm;
    logic [DUTY_W-1:0] r_soft_range;

    // Speed state
    logic signed [SPEED_W-1:0] r_target, n_target;
    logic signed [SPEED_W-1:0] r_ramped, n_ramped;
    logic                      r_enable, n_enable;
    logic                      r_held_dir, n_held_dir;

    // Pipeline
    logic              r_s1_valid;
    t_s1               r_s1, n_s1;
    logic [DUTY_W-1:0] div_duty;

    logic out_free, s1_free, accept;

    logic signed [SPEED_W:0] stepped;
    logic        [SPEED_W:0] stepped_mag;
    logic        [SPEED_W:0] target_mag;
    logic        [SPEED_W-1:0] cur_abs;
    logic        [MAG_W-1:0] cur_mag;
    logic        [DUTY_W-1:0] scale;
    logic signed [SPEED_W-1:0] req_clamped;
    logic                      written, fault;

    assign out_free = !o_valid || !i_stall;
    assign s1_free  = !r_s1_valid || out_free;
    assign o_stall  = !s1_free;
    assign accept   = i_valid && s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_step   <= RAMP_STEP_RESET;
            r_fault_sense <= 1'b0;
            r_enable_line <= 1'b0;
            r_hw_pwm      <= 1'b0;
            r_soft_range  <= SOFT_RANGE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RAMP_STEP:   r_ramp_step   <= i_cfg_data[STEP_W-1:0];
                CFG_FAULT_SENSE: r_fault_sense <= i_cfg_data[0];
                CFG_ENABLE_LINE: r_enable_line <= i_cfg_data[0];
                CFG_HW_PWM:      r_hw_pwm      <= i_cfg_data[0];
                CFG_SOFT_RANGE:  r_soft_range  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Ramp stage
    always_comb begin
        if (i_speed_request > REQ_MAX) begin
            req_clamped = SPEED_MAX;
        end else if (i_speed_request < REQ_MIN) begin
            req_clamped = SPEED_MIN;
        end else begin
            req_clamped = i_speed_request[SPEED_W-1:0];
        end

        if (r_target > r_ramped) begin
            stepped = {r_ramped[SPEED_W-1], r_ramped} + $signed({5'd0, r_ramp_step});
        end else begin
            stepped = {r_ramped[SPEED_W-1], r_ramped} - $signed({5'd0, r_ramp_step});
        end
        if (r_target == r_ramped) begin
            stepped = {r_ramped[SPEED_W-1], r_ramped};
        end
        stepped_mag = stepped[SPEED_W] ? -stepped : stepped;
        target_mag  = r_target[SPEED_W-1] ? -{1'b1, r_target} : {1'b0, r_target};

        cur_abs = r_ramped[SPEED_W-1] ? -r_ramped : r_ramped;
        cur_mag = cur_abs[MAG_W-1:0];
        scale   = r_hw_pwm ? DUTY_W'(HW_DUTY_SCALE) : r_soft_range;

        n_target   = r_target;
        n_ramped   = r_ramped;
        n_enable   = r_enable;
        n_held_dir = r_held_dir;
        written    = 1'b0;
        fault      = 1'b0;

        if (i_cmd) begin
            n_target = req_clamped;
            if (r_enable_line) begin
                n_enable = 1'b1;
            end
        end else if (r_fault_sense && !i_fault_pin_level) begin
            n_target = '0;
            if (r_enable_line) begin
                n_enable = 1'b0;
            end
            fault = 1'b1;
        end else begin
            if (r_target != r_ramped) begin
                written    = 1'b1;
                n_held_dir = r_ramped[SPEED_W-1];
            end
            // Snap to target when the stepped magnitude exceeds the target's
            if (stepped_mag > target_mag) begin
                n_ramped = r_target;
            end else begin
                n_ramped = stepped[SPEED_W-1:0];
            end
        end

        n_s1.written   = written;
        n_s1.direction = n_held_dir;
        n_s1.enable    = n_enable && r_enable_line;
        n_s1.current   = n_ramped;
        n_s1.fault     = fault;
        n_s1.prod      = PROD_W'(cur_mag) * PROD_W'(scale);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= '0;
            r_ramped   <= '0;
            r_enable   <= 1'b0;
            r_held_dir <= 1'b0;
        end else if (accept) begin
            r_target   <= n_target;
            r_ramped   <= n_ramped;
            r_enable   <= n_enable;
            r_held_dir <= n_held_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    // Duty stage
    msrp_duty_div u_duty_div (
        .i_prod (r_s1.prod),
        .o_duty (div_duty)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            o_duty  <= '0;
        end else if (out_free) begin
            o_valid <= r_s1_valid;
            // Hold the last written duty unless this word writes a new one
            if (r_s1_valid && r_s1.written) begin
                o_duty <= div_duty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            o_pwm_written   <= r_s1.written;
            o_direction     <= r_s1.direction;
            o_enable_out    <= r_s1.enable;
            o_current_speed <= r_s1.current;
            o_fault_stop    <= r_s1.fault;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/msrp_check.sv -----
// Port-level assertions for the motor speed ramp, bound to the top level.
`default_nettype none

module msrp_check
    import msrp_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      o_valid,
    input  wire logic                      i_stall,
    input  wire logic                      o_pwm_written,
    input  wire logic [DUTY_W-1:0]         o_duty,
    input  wire logic                      o_enable_out,
    input  wire logic signed [SPEED_W-1:0] o_current_speed,
    input  wire logic                      o_fault_stop
);

    localparam logic signed [SPEED_W-1:0] SPEED_MAX = SPEED_W'(FULL_SCALE);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_duty) && $stable(o_current_speed))
        else $error("stalled result changed");

    // A fault tick neither writes the PWM nor leaves the driver enabled
    a_fault_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_fault_stop |-> !o_pwm_written && !o_enable_out)
        else $error("fault tick wrote PWM or kept enable");

    // Ramped speed stays within full scale
    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_current_speed <= SPEED_MAX) && (o_current_speed >= -SPEED_MAX))
        else $error("current speed beyond full scale");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind motor_speed_ramp_pwm_top msrp_check u_msrp_check (.*);

`default_nettype wire

// ----- bench/motor_speed_ramp_pwm_top_test.sv -----
// Self-checking bench for the motor speed ramp with PWM output: predicts every result word.
module motor_speed_ramp_pwm_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import msrp_pkg::*;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_MOVE  = 1'b1;
    localparam logic PIN_FAULT = 1'b0;
    localparam logic PIN_OK    = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_WORDS = 210;
    localparam int NUM_PHASES  = 8;

    typedef struct packed {
        logic                      written;
        logic                      direction;
        logic [DUTY_W-1:0]         duty;
        logic                      enable;
        logic signed [SPEED_W-1:0] speed;
        logic                      fault;
    } t_ramp_result;

    class t_speed_ramp_scoreboard;
        logic [STEP_W-1:0] ramp_step;
        logic              fault_sense;
        logic              enable_line;
        logic              hw_pwm;
        logic [DUTY_W-1:0] soft_range;
        int                target;
        int                ramped;
        logic              enable_level;
        logic              held_dir;
        logic [DUTY_W-1:0] held_duty;
        t_ramp_result      expected_q[$];
        int                errors;

        function new();
            ramp_step    = RAMP_STEP_RESET;
            fault_sense  = 1'b0;
            enable_line  = 1'b0;
            hw_pwm       = 1'b0;
            soft_range   = SOFT_RANGE_RESET;
            target       = 0;
            ramped       = 0;
            enable_level = 1'b0;
            held_dir     = 1'b0;
            held_duty    = '0;
            errors       = 0;
        endfunction

        function int clamp_speed(int v);
            if (v < -FULL_SCALE) return -FULL_SCALE;
            if (v > FULL_SCALE) return FULL_SCALE;
            return v;
        endfunction

        function int magnitude(int v);
            return (v < 0) ? -v : v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DUTY_W-1:0] data);
            case (idx)
                CFG_RAMP_STEP:   ramp_step = data[STEP_W-1:0];
                CFG_FAULT_SENSE: fault_sense = data[0];
                CFG_ENABLE_LINE: enable_line = data[0];
                CFG_HW_PWM:      hw_pwm = data[0];
                CFG_SOFT_RANGE:  soft_range = data;
                default: ;
            endcase
        endfunction

        function void note_word(logic cmd, logic signed [REQ_W-1:0] req, logic pin);
            t_ramp_result r;
            longint       scale;
            r = '0;
            if (cmd == CMD_MOVE) begin
                target = clamp_speed(int'(req));
                if (enable_line) enable_level = 1'b1;
            end else if (fault_sense && pin == PIN_FAULT) begin
                // stop: target drops to zero, speed holds, no PWM write
                target = 0;
                if (enable_line) enable_level = 1'b0;
                r.fault = 1'b1;
            end else begin
                if (target != ramped) begin
                    // the old speed goes out, then the ramp advances
                    scale = hw_pwm ? longint'(HW_DUTY_SCALE) : longint'(soft_range);
                    held_dir = (ramped < 0);
                    held_duty = DUTY_W'(longint'(magnitude(clamp_speed(ramped))) * scale
                                        / longint'(FULL_SCALE));
                    r.written = 1'b1;
                    if (target > ramped) ramped += int'(ramp_step);
                    else ramped -= int'(ramp_step);
                end
                if (magnitude(ramped) > magnitude(target)) ramped = target;
            end
            r.direction = held_dir;
            r.duty      = held_duty;
            r.enable    = enable_level & enable_line;
            r.speed     = SPEED_W'(ramped);
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_word(t_ramp_result act);
            t_ramp_result e;
            if (expected_q.size() == 0) begin
                $error("result word arrived with nothing expected");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            compare_field("pwm_written", e.written, act.written);
            compare_field("direction", e.direction, act.direction);
            compare_field("duty", e.duty, act.duty);
            compare_field("enable_out", e.enable, act.enable);
            compare_field("current_speed", longint'($signed(e.speed)),
                          longint'($signed(act.speed)));
            compare_field("fault_stop", e.fault, act.fault);
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_idx = '0;
    logic [DUTY_W-1:0]         i_cfg_data = '0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic                      i_cmd = 1'b0;
    logic signed [REQ_W-1:0]   i_speed_request = '0;
    logic                      i_fault_pin_level = 1'b1;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic                      o_pwm_written;
    logic                      o_direction;
    logic [DUTY_W-1:0]         o_duty;
    logic                      o_enable_out;
    logic signed [SPEED_W-1:0] o_current_speed;
    logic                      o_fault_stop;

    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int cycle_count = 0;

    t_speed_ramp_scoreboard sb = new();

    motor_speed_ramp_pwm_top i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_cmd             (i_cmd),
        .i_speed_request   (i_speed_request),
        .i_fault_pin_level (i_fault_pin_level),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_pwm_written     (o_pwm_written),
        .o_direction       (o_direction),
        .o_duty            (o_duty),
        .o_enable_out      (o_enable_out),
        .o_current_speed   (o_current_speed),
        .o_fault_stop      (o_fault_stop)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // receiver: long hold-off when asked, else random stall
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            sb.note_word(i_cmd, i_speed_request, i_fault_pin_level);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_word(t_ramp_result'({o_pwm_written, o_direction, o_duty, o_enable_out,
                                          o_current_speed, o_fault_stop}));
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    task automatic send_word(input logic cmd, input logic signed [REQ_W-1:0] req,
                             input logic pin);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_cmd             <= cmd;
        i_speed_request   <= req;
        i_fault_pin_level <= pin;
        do @(posedge i_clk); while (o_stall);
    endtask

    // drop valid and wait out every outstanding result plus the pipeline tail
    task automatic finish_burst();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUTY_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // upper data bits are random: the block must keep only the register width
    task automatic apply_settings(input logic [STEP_W-1:0] step_v, input logic fsense,
                                  input logic eline, input logic hw,
                                  input logic [DUTY_W-1:0] range_v);
        put_reg(CFG_RAMP_STEP, {(DUTY_W-STEP_W)'($urandom), step_v});
        put_reg(CFG_FAULT_SENSE, {(DUTY_W-1)'($urandom), fsense});
        put_reg(CFG_ENABLE_LINE, {(DUTY_W-1)'($urandom), eline});
        put_reg(CFG_HW_PWM, {(DUTY_W-1)'($urandom), hw});
        put_reg(CFG_SOFT_RANGE, range_v);
        put_reg(CFG_UNUSED_IDX, DUTY_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_random_word();
        logic signed [REQ_W-1:0] req;
        int                      pick;
        pick = $urandom_range(99);
        req  = REQ_W'($urandom);
        if (pick < 22) begin
            case ($urandom_range(9))
                0: ;
                1: begin
                    case ($urandom_range(5))
                        0: req = 16'sd32767;
                        1: req = 16'h8000;
                        2: req = 16'sd1000;
                        3: req = -16'sd1000;
                        4: req = 16'sd1001;
                        default: req = -16'sd1001;
                    endcase
                end
                default: req = REQ_W'(int'($urandom_range(2200)) - 1100);
            endcase
            send_word(CMD_MOVE, req, 1'($urandom));
        end else begin
            send_word(CMD_TICK, req, ($urandom_range(99) < 8) ? PIN_FAULT : PIN_OK);
        end
    endtask

    initial begin : stimulus
        int                p;
        int                n;
        logic [STEP_W-1:0] step_v;
        logic [DUTY_W-1:0] range_v;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: clamp at both ends, ramp across zero, pin ignored
        send_word(CMD_MOVE, 16'sd32767, PIN_OK);
        send_word(CMD_TICK, 16'sd0, PIN_OK);
        send_word(CMD_TICK, 16'sd0, PIN_OK);
        send_word(CMD_MOVE, 16'h8000, PIN_OK);
        send_word(CMD_TICK, 16'sd0, PIN_OK);
        send_word(CMD_TICK, 16'sd0, PIN_OK);
        send_word(CMD_TICK, 16'sd0, PIN_FAULT);
        send_word(CMD_MOVE, 16'sd0, PIN_OK);
        send_word(CMD_TICK, 16'sd0, PIN_OK);
        finish_burst();

        // fault sense, enable line, hardware scale, widest step
        apply_settings(7'd127, 1'b1, 1'b1, 1'b1, SOFT_RANGE_RESET);
        send_word(CMD_MOVE, 16'sd1001, PIN_OK);
        send_word(CMD_TICK, 16'sd0, PIN_OK);
        send_word(CMD_TICK, 16'sd0, PIN_FAULT);
        send_word(CMD_TICK, 16'sd0, PIN_OK);
        send_word(CMD_MOVE, -16'sd1001, PIN_FAULT);
        send_word(CMD_TICK, 16'sd0, PIN_OK);
        send_word(CMD_TICK, 16'sd0, PIN_OK);
        send_word(CMD_TICK, 16'sd0, PIN_OK);
        send_word(CMD_MOVE, 16'sd3, PIN_OK);
        send_word(CMD_TICK, 16'sd0, PIN_OK);
        send_word(CMD_TICK, 16'sd0, PIN_OK);
        finish_burst();

        // zero step never moves, zero software range gives zero duty
        apply_settings(7'd0, 1'b0, 1'b1, 1'b0, 20'd0);
        send_word(CMD_MOVE, 16'sd500, PIN_OK);
        send_word(CMD_TICK, 16'sd0, PIN_OK);
        send_word(CMD_TICK, 16'sd0, PIN_OK);
        finish_burst();

        for (p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: step_v = 7'd1;
                1: step_v = 7'd100;
                2: step_v = 7'd127;
                3: step_v = 7'd0;
                default: step_v = STEP_W'($urandom_range(1, 100));
            endcase
            case (p)
                0: range_v = 20'd1;
                1: range_v = 20'd1000000;
                2: range_v = 20'hFFFFF;
                3: range_v = 20'd0;
                4: range_v = SOFT_RANGE_RESET;
                default: range_v = DUTY_W'($urandom_range(1, 1000000));
            endcase
            apply_settings(step_v, p[0], p[1] ^ p[2], (p == 5 || p == 7), range_v);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 54; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 54; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            for (n = 0; n < PHASE_WORDS; n++) begin
                // hold the receiver off while words keep coming: fill the pipe
                if (p == 0 && n == 60) hold_left = 80;
                if (p == 4 && n == 100) finish_burst();
                send_random_word();
            end
            finish_burst();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/msrp_pkg.sv
rtl/msrp_duty_div.sv
rtl/motor_speed_ramp_pwm_top.sv
rtl/msrp_check.sv
bench/motor_speed_ramp_pwm_top_test.sv
